// File: hdl/icc_pkg.sv
`timescale 1ns / 1ps

package icc_pkg;

   // field widths fixed by the register map and item layout
   localparam int unsigned DELAY_W  = 16;
   localparam int unsigned PKTS_W   = 8;
   localparam int unsigned QUSE_W   = 4;
   localparam int unsigned WORD_W   = 32;
   localparam int unsigned OPC_W    = 3;
   localparam int unsigned QSEL_W   = 3;
   localparam int unsigned CSR_IX_W = 8;

   // pending count saturates here
   localparam logic [PKTS_W-1:0] COUNT_MAX = 8'hFF;

   // configuration register indexes
   localparam logic [CSR_IX_W-1:0] REG_MAX_DELAY     = 8'd0;
   localparam logic [CSR_IX_W-1:0] REG_PKT_LIMIT     = 8'd1;
   localparam logic [CSR_IX_W-1:0] REG_QUEUES_IN_USE = 8'd2;
   localparam logic [CSR_IX_W-1:0] REG_TIMER_CAUSE   = 8'd3;

   // item operations
   typedef enum logic [OPC_W-1:0] {
      OP_TICK      = 3'd0,
      OP_EVENT     = 3'd1,
      OP_MASK_SET  = 3'd2,
      OP_MASK_CLR  = 3'd3,
      OP_CAUSE_RD  = 3'd4,
      OP_CAUSE_CLR = 3'd5
   } op_type;

   // controller sequencing
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EVENT,
      ST_FINISH
   } state_type;

   // one per-queue entry held in the queue memory
   typedef struct packed {
      logic [PKTS_W-1:0] count;
      logic [WORD_W-1:0] stamp;
   } entry_type;

endpackage

// File: hdl/icc_if.sv
`timescale 1ns / 1ps

// request channel: one operation per transfer
interface icc_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  opcode;
   logic [2:0]  queue;
   logic [31:0] cause_bits;
   logic [31:0] now;
   logic [31:0] write_bits;

   modport source (output valid, opcode, queue, cause_bits, now, write_bits, input ready);
   modport sink   (input valid, opcode, queue, cause_bits, now, write_bits, output ready);
endinterface

// response channel: one result per request
interface icc_rsp_if;
   logic        valid;
   logic        ready;
   logic        irq_fire;
   logic        irq_pending;
   logic [31:0] read_data;
   logic [31:0] coalesced_total;

   modport source (output valid, irq_fire, irq_pending, read_data, coalesced_total,
                   input ready);
   modport sink   (input valid, irq_fire, irq_pending, read_data, coalesced_total,
                   output ready);
endinterface

// configuration write channel
interface icc_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/icc_ram.sv
`timescale 1ns / 1ps

module icc_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/interrupt_coalescing_controller.sv
`timescale 1ns / 1ps

// Interrupt coalescing controller. Completion events count up per queue in a
// small memory (pending count and first-event stamp); an event that reaches
// the packet threshold, or a tick that finds an active queue whose max_delay
// has run out, raises a cause into the cause register, and a raised cause that
// hits the mask while no interrupt is pending fires one interrupt. Each request
// gives exactly one response. Requests are handled one at a time: mask and
// cause operations, ignored events and ticks with timeouts off or no queue to
// scan go straight to the result; a completion event passes through memory
// read, update and write back, and result; a scanning tick reads the first
// min(queues_in_use, QUEUE_COUNT) queue entries, one per cycle through the
// single memory read port while the previous entry is updated, then finishes
// the last entry and sees the scan empty. A finished result sits in an output
// register, so the response side may stall while the next request is being
// worked on. The queue memory needs no clearing pass: a valid bit per queue
// makes unwritten entries read as zero straight out of reset. Configuration
// writes are taken in any cycle outside reset and must only be issued while no
// request is outstanding.
module interrupt_coalescing_controller
   import icc_pkg::*;
#(
   parameter int QUEUE_COUNT = 8,
   localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1,
   localparam int CW = $clog2(QUEUE_COUNT + 1)
) (
   input  logic       clock,
   input  logic       reset,
   icc_req_if.sink    req_if,
   icc_rsp_if.source  rsp_if,
   icc_csr_if.sink    csr_if
);

   localparam logic [CW-1:0] QCNT = CW'(QUEUE_COUNT);

   // configuration
   logic [DELAY_W-1:0] max_delay_ff;
   logic [PKTS_W-1:0]  pkt_limit_ff;
   logic [QUSE_W-1:0]  queues_in_use_ff;
   logic [WORD_W-1:0]  timer_cause_ff;

   // controller state
   state_type          state_ff, state_in;
   logic [WORD_W-1:0]  cur_time_ff, cur_time_in;
   logic [WORD_W-1:0]  cause_ff, cause_in;
   logic [WORD_W-1:0]  mask_ff, mask_in;
   logic               pend_ff, pend_in;
   logic [WORD_W-1:0]  supp_ff, supp_in;
   logic               fired_ff, fired_in;
   logic [WORD_W-1:0]  rdata_ff, rdata_in;
   logic [QW-1:0]      ev_q_ff, ev_q_in;
   logic [WORD_W-1:0]  ev_cause_ff, ev_cause_in;
   logic [CW-1:0]      scan_n_ff, scan_n_in;
   logic [CW-1:0]      rd_q_ff, rd_q_in;
   logic [QW-1:0]      proc_q_ff, proc_q_in;
   logic               proc_valid_ff, proc_valid_in;
   logic [QUEUE_COUNT-1:0] valid_ff, valid_in;
   logic               rdv_ff, rdv_in;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_fire_ff, rsp_fire_in;
   logic               rsp_pend_ff, rsp_pend_in;
   logic [WORD_W-1:0]  rsp_rdata_ff, rsp_rdata_in;
   logic [WORD_W-1:0]  rsp_total_ff, rsp_total_in;

   // memory port
   logic               ram_wr_en, ram_rd_en;
   logic [QW-1:0]      ram_wr_addr, ram_rd_addr;
   entry_type          ram_wr_data, ram_rd_data;

   // helpers
   logic               accept, rsp_free, coal_on, scan_go, q_ok, scan_done;
   logic [CW-1:0]      n_lim;
   op_type             op;
   entry_type          entry_cur;
   logic [WORD_W-1:0]  elapsed;
   logic [PKTS_W-1:0]  cnt_inc;
   logic               raise_en;
   logic [WORD_W-1:0]  raise_bits;

   icc_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (QUEUE_COUNT)
   ) u_icc_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // decode and shared conditions
   always_comb begin
      op        = op_type'(req_if.opcode);
      accept    = req_if.valid && req_if.ready;
      rsp_free  = !rsp_valid_ff || rsp_if.ready;
      coal_on   = (max_delay_ff != '0) || (pkt_limit_ff > 8'd1);
      q_ok      = int'(req_if.queue) < QUEUE_COUNT;
      if (int'(queues_in_use_ff) > QUEUE_COUNT) begin
         n_lim = QCNT;
      end else begin
         n_lim = CW'(queues_in_use_ff);
      end
      scan_go   = coal_on && (max_delay_ff != '0) && (n_lim != '0);
      scan_done = (rd_q_ff == scan_n_ff) && !proc_valid_ff;
      entry_cur = rdv_ff ? ram_rd_data : '0;
      elapsed   = cur_time_ff - entry_cur.stamp;
      cnt_inc   = (entry_cur.count != COUNT_MAX) ? entry_cur.count + 8'd1 : entry_cur.count;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (op)
                  OP_TICK:  state_in = scan_go ? ST_SCAN : ST_FINISH;
                  OP_EVENT: state_in = q_ok ? ST_EVENT : ST_FINISH;
                  default:  state_in = ST_FINISH;
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_EVENT:  state_in = ST_FINISH;
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_if.ready  = (state_ff == ST_IDLE) && !reset;
      csr_if.ready  = !reset;

      cur_time_in   = cur_time_ff;
      cause_in      = cause_ff;
      mask_in       = mask_ff;
      pend_in       = pend_ff;
      supp_in       = supp_ff;
      fired_in      = fired_ff;
      rdata_in      = rdata_ff;
      ev_q_in       = ev_q_ff;
      ev_cause_in   = ev_cause_ff;
      scan_n_in     = scan_n_ff;
      rd_q_in       = rd_q_ff;
      proc_q_in     = proc_q_ff;
      proc_valid_in = proc_valid_ff;
      valid_in      = valid_ff;
      rdv_in        = rdv_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_fire_in   = rsp_fire_ff;
      rsp_pend_in   = rsp_pend_ff;
      rsp_rdata_in  = rsp_rdata_ff;
      rsp_total_in  = rsp_total_ff;

      ram_wr_en     = 1'b0;
      ram_wr_addr   = proc_q_ff;
      ram_wr_data   = entry_cur;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = QW'(req_if.queue);

      raise_en      = 1'b0;
      raise_bits    = '0;

      case (state_ff)
         // request transfer: register operations act at once
         ST_IDLE: begin
            if (accept) begin
               fired_in    = 1'b0;
               rdata_in    = '0;
               ev_q_in     = QW'(req_if.queue);
               ev_cause_in = req_if.cause_bits;
               rd_q_in     = '0;
               proc_valid_in = 1'b0;
               scan_n_in   = n_lim;
               case (op)
                  OP_TICK:      cur_time_in = req_if.now;
                  OP_EVENT:     ram_rd_en   = q_ok;
                  OP_MASK_SET:  mask_in     = mask_ff | req_if.write_bits;
                  OP_MASK_CLR:  mask_in     = mask_ff & ~req_if.write_bits;
                  OP_CAUSE_RD: begin
                     rdata_in = cause_ff;
                     cause_in = '0;
                  end
                  OP_CAUSE_CLR: cause_in    = cause_ff & ~req_if.write_bits;
                  default:      ;
               endcase
            end
         end
         // timeout scan: read the next queue while updating the previous one
         ST_SCAN: begin
            if (rd_q_ff != scan_n_ff) begin
               ram_rd_en     = 1'b1;
               ram_rd_addr   = rd_q_ff[QW-1:0];
               rd_q_in       = rd_q_ff + CW'(1);
               proc_q_in     = rd_q_ff[QW-1:0];
               proc_valid_in = 1'b1;
            end else begin
               proc_valid_in = 1'b0;
            end
            if (proc_valid_ff && (entry_cur.count != '0) &&
                (elapsed >= WORD_W'(max_delay_ff))) begin
               ram_wr_en         = 1'b1;
               ram_wr_addr       = proc_q_ff;
               ram_wr_data.count = '0;
               ram_wr_data.stamp = entry_cur.stamp;
               supp_in    = supp_ff + WORD_W'(entry_cur.count - 8'd1);
               raise_en   = 1'b1;
               raise_bits = timer_cause_ff;
            end
         end
         // completion event: update and write back its queue entry
         ST_EVENT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = ev_q_ff;
            ram_wr_data.stamp = entry_cur.stamp;
            ram_wr_data.count = cnt_inc;
            if (!coal_on) begin
               ram_wr_data.count = '0;
               raise_en   = 1'b1;
               raise_bits = ev_cause_ff;
            end else begin
               if (cnt_inc == 8'd1) begin
                  ram_wr_data.stamp = cur_time_ff;
               end
               if (cnt_inc >= pkt_limit_ff) begin
                  ram_wr_data.count = '0;
                  supp_in    = supp_ff + WORD_W'(cnt_inc - 8'd1);
                  raise_en   = 1'b1;
                  raise_bits = ev_cause_ff;
               end
            end
         end
         // result into the response register, pending cleared on empty cause
         ST_FINISH: begin
            if (rsp_free) begin
               pend_in      = pend_ff && (cause_ff != '0);
               rsp_valid_in = 1'b1;
               rsp_fire_in  = fired_ff;
               rsp_pend_in  = pend_ff && (cause_ff != '0);
               rsp_rdata_in = rdata_ff;
               rsp_total_in = supp_ff;
            end
         end
         default: ;
      endcase

      // cause raise and interrupt delivery
      if (raise_en) begin
         cause_in = cause_ff | raise_bits;
         if (((raise_bits & mask_ff) != '0) && !pend_ff) begin
            pend_in  = 1'b1;
            fired_in = 1'b1;
         end
      end

      if (ram_wr_en) begin
         valid_in[ram_wr_addr] = 1'b1;
      end
      if (ram_rd_en) begin
         rdv_in = valid_ff[ram_rd_addr];
      end

      rsp_if.valid           = rsp_valid_ff;
      rsp_if.irq_fire        = rsp_fire_ff;
      rsp_if.irq_pending     = rsp_pend_ff;
      rsp_if.read_data       = rsp_rdata_ff;
      rsp_if.coalesced_total = rsp_total_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         max_delay_ff     <= '0;
         pkt_limit_ff     <= '0;
         queues_in_use_ff <= 4'd1;
         timer_cause_ff   <= 32'd1;
         cur_time_ff      <= '0;
         cause_ff         <= '0;
         mask_ff          <= '0;
         pend_ff          <= 1'b0;
         supp_ff          <= '0;
         proc_valid_ff    <= 1'b0;
         valid_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         cur_time_ff      <= cur_time_in;
         cause_ff         <= cause_in;
         mask_ff          <= mask_in;
         pend_ff          <= pend_in;
         supp_ff          <= supp_in;
         proc_valid_ff    <= proc_valid_in;
         valid_ff         <= valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         // configuration transfer
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               REG_MAX_DELAY:     max_delay_ff     <= csr_if.data[DELAY_W-1:0];
               REG_PKT_LIMIT:     pkt_limit_ff     <= csr_if.data[PKTS_W-1:0];
               REG_QUEUES_IN_USE: queues_in_use_ff <= csr_if.data[QUSE_W-1:0];
               REG_TIMER_CAUSE:   timer_cause_ff   <= csr_if.data;
               default:           ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      fired_ff     <= fired_in;
      rdata_ff     <= rdata_in;
      ev_q_ff      <= ev_q_in;
      ev_cause_ff  <= ev_cause_in;
      scan_n_ff    <= scan_n_in;
      rd_q_ff      <= rd_q_in;
      proc_q_ff    <= proc_q_in;
      rdv_ff       <= rdv_in;
      rsp_fire_ff  <= rsp_fire_in;
      rsp_pend_ff  <= rsp_pend_in;
      rsp_rdata_ff <= rsp_rdata_in;
      rsp_total_ff <= rsp_total_in;
   end

endmodule

// File: hdl/icc_checker.sv
`timescale 1ns / 1ps

module icc_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic irq_fire,
   input logic irq_pending
);

   logic [1:0] outstanding_ff;
   logic       last_pend_ff;

   // requests taken but not yet answered, and pending flag of the last result
   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
         last_pend_ff   <= 1'b0;
      end else begin
         outstanding_ff <= outstanding_ff + 2'(req_valid && req_ready)
                                          - 2'(rsp_valid && rsp_ready);
         if (rsp_valid && rsp_ready) begin
            last_pend_ff <= irq_pending;
         end
      end
   end

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // a delivered interrupt leaves the pending flag set
   a_fire_pend: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && irq_fire |-> irq_pending)
      else $error("interrupt fired without pending flag");

   // no new interrupt while the previous result left one pending
   a_fire_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && irq_fire |-> !last_pend_ff)
      else $error("interrupt fired while one was pending");

   // every result answers a request
   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outstanding_ff != 2'd0)
      else $error("result with no request outstanding");

   // at most one request in work and one result waiting
   a_depth: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff != 2'd3)
      else $error("too many requests outstanding");

endmodule

bind interrupt_coalescing_controller icc_checker u_icc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .irq_fire    (rsp_if.irq_fire),
   .irq_pending (rsp_if.irq_pending)
);

// File: sim/tb_interrupt_coalescing_controller.sv
`timescale 1ns / 1ps

module tb_interrupt_coalescing_controller;
   import icc_pkg::*;

   localparam int QUEUES_BUILT   = 8;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int END_PAUSE      = 16;

   // opcodes the block must treat as no-ops
   localparam logic [OPC_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OPC_W-1:0] OP_SPARE_7 = 3'd7;

   typedef struct {
      logic              fire;
      logic              pend;
      logic [WORD_W-1:0] rdata;
      logic [WORD_W-1:0] total;
   } irq_result_type;

   logic clock;
   logic reset;

   icc_req_if req_bus ();
   icc_rsp_if rsp_bus ();
   icc_csr_if csr_bus ();

   interrupt_coalescing_controller #(.QUEUE_COUNT(QUEUES_BUILT)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // shadow copy of the coalescing state
   logic [PKTS_W-1:0]  backlog [QUEUES_BUILT]    = '{default: '0};
   logic [WORD_W-1:0]  first_seen [QUEUES_BUILT] = '{default: '0};
   logic [WORD_W-1:0]  now_time         = '0;
   logic [WORD_W-1:0]  cause_reg        = '0;
   logic [WORD_W-1:0]  irq_mask         = '0;
   logic               irq_held         = 1'b0;
   logic [WORD_W-1:0]  suppressed_total = '0;

   // shadow copy of the register file
   logic [DELAY_W-1:0] cfg_delay       = '0;
   logic [PKTS_W-1:0]  cfg_packets     = '0;
   logic [QUSE_W-1:0]  cfg_queues      = 4'd1;
   logic [WORD_W-1:0]  cfg_timer_cause = 32'd1;

   irq_result_type     pending_results [$];

   logic               idle_enable   = 1'b1;
   logic               req_open      = 1'b0;
   logic               csr_open      = 1'b0;
   int                 hold_off_len  = 0;
   logic [WORD_W-1:0]  tick_base     = '0;

   int                 mismatch_count = 0;
   int                 items_sent     = 0;
   int                 results_seen   = 0;
   int                 fires_seen     = 0;
   int                 timeouts_seen  = 0;
   int                 config_count   = 0;

   function automatic logic coalescing_active();
      return (cfg_delay != '0) || (cfg_packets > 8'd1);
   endfunction

   // or a cause into the register; deliver only if masked in and nothing pending
   function automatic logic raise_cause(input logic [WORD_W-1:0] cause);
      cause_reg = cause_reg | cause;
      if ((cause & irq_mask) != '0 && !irq_held) begin
         irq_held = 1'b1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // tick: scan the queues in use for an expired delay
   function automatic logic scan_timeouts(input logic [WORD_W-1:0] stamp_now);
      logic              fired;
      int                scan_len;
      logic [WORD_W-1:0] elapsed;
      fired = 1'b0;
      now_time = stamp_now;
      if (coalescing_active() && cfg_delay != '0) begin
         scan_len = (cfg_queues > QUEUES_BUILT) ? QUEUES_BUILT : int'(cfg_queues);
         for (int q = 0; q < scan_len; q++) begin
            elapsed = now_time - first_seen[q];
            if (backlog[q] != '0 && elapsed >= {16'd0, cfg_delay}) begin
               suppressed_total = suppressed_total + 32'(backlog[q]) - 32'd1;
               backlog[q] = '0;
               timeouts_seen++;
               if (raise_cause(cfg_timer_cause))
                  fired = 1'b1;
            end
         end
      end
      return fired;
   endfunction

   // completion event: count it, fire at the packet threshold
   function automatic logic count_completion(input logic [QSEL_W-1:0] qsel,
                                             input logic [WORD_W-1:0] cause);
      logic fired;
      fired = 1'b0;
      if (qsel < QUEUES_BUILT) begin
         if (backlog[qsel] < COUNT_MAX)
            backlog[qsel] = backlog[qsel] + 8'd1;
         if (!coalescing_active()) begin
            backlog[qsel] = '0;
            fired = raise_cause(cause);
         end else begin
            if (backlog[qsel] == 8'd1)
               first_seen[qsel] = now_time;
            if (backlog[qsel] >= cfg_packets) begin
               suppressed_total = suppressed_total + 32'(backlog[qsel]) - 32'd1;
               backlog[qsel] = '0;
               fired = raise_cause(cause);
            end
         end
      end
      return fired;
   endfunction

   function automatic irq_result_type predict_interrupt(input logic [OPC_W-1:0]  op,
                                                        input logic [QSEL_W-1:0] qsel,
                                                        input logic [WORD_W-1:0] cause,
                                                        input logic [WORD_W-1:0] stamp_now,
                                                        input logic [WORD_W-1:0] bits);
      irq_result_type r;
      r.fire  = 1'b0;
      r.rdata = '0;
      case (op)
         OP_TICK:      r.fire = scan_timeouts(stamp_now);
         OP_EVENT:     r.fire = count_completion(qsel, cause);
         OP_MASK_SET:  irq_mask = irq_mask | bits;
         OP_MASK_CLR:  irq_mask = irq_mask & ~bits;
         OP_CAUSE_RD: begin
            r.rdata   = cause_reg;
            cause_reg = '0;
         end
         OP_CAUSE_CLR: cause_reg = cause_reg & ~bits;
         default: ;
      endcase
      // pending flag drops once nothing is left in the cause register
      if (cause_reg == '0)
         irq_held = 1'b0;
      r.pend  = irq_held;
      r.total = suppressed_total;
      if (r.fire)
         fires_seen++;
      return r;
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // request transfer: valid stays high after acceptance until the next gap or drain
   task automatic send_item(input logic [OPC_W-1:0]  op,
                            input logic [QSEL_W-1:0] qsel,
                            input logic [WORD_W-1:0] cause,
                            input logic [WORD_W-1:0] stamp_now,
                            input logic [WORD_W-1:0] bits);
      if (csr_open) begin
         csr_bus.valid <= 1'b0;
         csr_open = 1'b0;
      end
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         if (req_open) begin
            req_bus.valid <= 1'b0;
            req_open = 1'b0;
         end
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.opcode     <= op;
      req_bus.queue      <= qsel;
      req_bus.cause_bits <= cause;
      req_bus.now        <= stamp_now;
      req_bus.write_bits <= bits;
      req_open = 1'b1;
      do
         @(posedge clock);
      while (req_bus.ready !== 1'b1);
      pending_results.insert(pending_results.size(),
                             predict_interrupt(op, qsel, cause, stamp_now, bits));
      items_sent++;
   endtask

   // wait until every expected result has been seen
   task automatic drain();
      if (req_open) begin
         req_bus.valid <= 1'b0;
         req_open = 1'b0;
      end
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IX_W-1:0] idx, input logic [WORD_W-1:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      csr_open = 1'b1;
      do
         @(posedge clock);
      while (csr_bus.ready !== 1'b1);
      case (idx)
         REG_MAX_DELAY:     cfg_delay       = val[DELAY_W-1:0];
         REG_PKT_LIMIT:     cfg_packets     = val[PKTS_W-1:0];
         REG_QUEUES_IN_USE: cfg_queues      = val[QUSE_W-1:0];
         REG_TIMER_CAUSE:   cfg_timer_cause = val;
         default: ;
      endcase
   endtask

   // registers change only with the block idle
   task automatic configure(input logic [DELAY_W-1:0] dly, input logic [PKTS_W-1:0] pkts,
                            input logic [QUSE_W-1:0] quse, input logic [WORD_W-1:0] tcause);
      drain();
      write_csr(REG_MAX_DELAY, {16'd0, dly});
      write_csr(REG_PKT_LIMIT, {24'd0, pkts});
      write_csr(REG_QUEUES_IN_USE, {28'd0, quse});
      write_csr(REG_TIMER_CAUSE, tcause);
      config_count++;
   endtask

   // mostly events and advancing ticks, with register traffic mixed in
   task automatic send_random_item();
      int unsigned       pick;
      logic [OPC_W-1:0]  op;
      logic [WORD_W-1:0] stamp_now;
      pick = $urandom_range(0, 99);
      if (pick < 45)
         op = OP_EVENT;
      else if (pick < 70)
         op = OP_TICK;
      else if (pick < 80)
         op = OP_CAUSE_RD;
      else if (pick < 87)
         op = OP_CAUSE_CLR;
      else if (pick < 93)
         op = OP_MASK_SET;
      else if (pick < 98)
         op = OP_MASK_CLR;
      else
         op = ($urandom_range(0, 1) != 0) ? OP_SPARE_6 : OP_SPARE_7;
      stamp_now = $urandom;
      if (op == OP_TICK && $urandom_range(0, 15) != 0) begin
         tick_base = tick_base + $urandom_range(0, int'(cfg_delay) / 2 + 2);
         stamp_now = tick_base;
      end else if (op == OP_TICK) begin
         tick_base = stamp_now;
      end
      send_item(op, QSEL_W'($urandom_range(0, 7)), $urandom, stamp_now, $urandom);
   endtask

   // coalescing off at reset defaults: every event raises its own cause
   task automatic test_default_config();
      send_item(OP_EVENT, 3'd0, 32'h0000_0001, $urandom, $urandom);
      send_item(OP_MASK_SET, QSEL_W'($urandom), $urandom, $urandom, 32'hFFFF_FFFF);
      send_item(OP_EVENT, 3'd7, 32'h8000_0000, $urandom, $urandom);
      send_item(OP_EVENT, 3'd2, 32'h0000_FFFF, $urandom, $urandom);
      send_item(OP_SPARE_6, QSEL_W'($urandom), $urandom, $urandom, $urandom);
      send_item(OP_SPARE_7, QSEL_W'($urandom), $urandom, $urandom, $urandom);
      send_item(OP_CAUSE_RD, QSEL_W'($urandom), $urandom, $urandom, $urandom);
      send_item(OP_CAUSE_RD, QSEL_W'($urandom), $urandom, $urandom, $urandom);
      send_item(OP_TICK, QSEL_W'($urandom), $urandom, 32'hFFFF_FFFF, $urandom);
      send_item(OP_EVENT, 3'd1, 32'h0000_0000, $urandom, $urandom);
      send_item(OP_EVENT, 3'd3, 32'hA5A5_A5A5, $urandom, $urandom);
      send_item(OP_CAUSE_CLR, QSEL_W'($urandom), $urandom, $urandom, 32'hA5A5_A5A5);
      send_item(OP_MASK_CLR, QSEL_W'($urandom), $urandom, $urandom, 32'hFFFF_FFFF);
   endtask

   // threshold of 0 or 1 with coalescing on fires on every event
   task automatic test_small_threshold();
      configure(16'd5, 8'd1, 4'd1, 32'd1);
      send_item(OP_MASK_SET, QSEL_W'($urandom), $urandom, $urandom, 32'h0000_0001);
      send_item(OP_EVENT, 3'd0, 32'h0000_0002, $urandom, $urandom);
      send_item(OP_EVENT, 3'd0, 32'h0000_0001, $urandom, $urandom);
      send_item(OP_CAUSE_RD, QSEL_W'($urandom), $urandom, $urandom, $urandom);
      configure(16'd7, 8'd0, 4'd8, 32'hFFFF_FFFF);
      send_item(OP_EVENT, 3'd4, 32'h0000_0001, $urandom, $urandom);
      send_item(OP_CAUSE_RD, QSEL_W'($urandom), $urandom, $urandom, $urandom);
   endtask

   // elapsed time across the 32-bit wrap, two queues expiring on one tick, empty scan
   task automatic test_timeout_wrap();
      configure(16'd10, 8'hFF, 4'd15, 32'h0000_0001);
      send_item(OP_MASK_SET, QSEL_W'($urandom), $urandom, $urandom, 32'hFFFF_FFFF);
      send_item(OP_TICK, QSEL_W'($urandom), $urandom, 32'hFFFF_FFF0, $urandom);
      send_item(OP_EVENT, 3'd1, $urandom, $urandom, $urandom);
      send_item(OP_EVENT, 3'd6, $urandom, $urandom, $urandom);
      send_item(OP_EVENT, 3'd6, $urandom, $urandom, $urandom);
      send_item(OP_TICK, QSEL_W'($urandom), $urandom, 32'hFFFF_FFF9, $urandom);
      send_item(OP_TICK, QSEL_W'($urandom), $urandom, 32'h0000_0005, $urandom);
      send_item(OP_CAUSE_RD, QSEL_W'($urandom), $urandom, $urandom, $urandom);
      configure(16'd10, 8'hFF, 4'd0, 32'h0000_0002);
      send_item(OP_EVENT, 3'd0, $urandom, $urandom, $urandom);
      send_item(OP_TICK, QSEL_W'($urandom), $urandom, 32'h0001_0000, $urandom);
      tick_base = 32'h0001_0000;
   endtask

   // the largest threshold: 255 events on one queue before the interrupt
   task automatic test_packet_threshold();
      configure(16'd0, 8'hFF, 4'd8, 32'h0000_0001);
      send_item(OP_MASK_SET, QSEL_W'($urandom), $urandom, $urandom, 32'hFFFF_FFFF);
      for (int n = 0; n < 255; n++)
         send_item(OP_EVENT, 3'd5, $urandom, $urandom, $urandom);
      send_item(OP_CAUSE_RD, QSEL_W'($urandom), $urandom, $urandom, $urandom);
   endtask

   // receiver holds off while requests keep coming, then the sender waits for all results
   task automatic test_backpressure();
      configure(16'd8, 8'd3, 4'd8, 32'h0000_000F);
      idle_enable  = 1'b0;
      hold_off_len = 300;
      for (int n = 0; n < 40; n++)
         send_random_item();
      drain();
      idle_enable = 1'b1;
   endtask

   task automatic random_config();
      logic [DELAY_W-1:0] dly;
      logic [PKTS_W-1:0]  pkts;
      logic [QUSE_W-1:0]  quse;
      logic [WORD_W-1:0]  tcause;
      case ($urandom_range(0, 5))
         0: begin
            dly  = '0;
            pkts = PKTS_W'($urandom_range(0, 1));
         end
         1: begin
            dly  = DELAY_W'($urandom_range(1, 40));
            pkts = PKTS_W'($urandom_range(0, 1));
         end
         2: begin
            dly  = '0;
            pkts = PKTS_W'($urandom_range(2, 8));
         end
         3: begin
            dly  = DELAY_W'($urandom_range(1, 40));
            pkts = PKTS_W'($urandom_range(2, 10));
         end
         4: begin
            dly  = 16'hFFFF;
            pkts = 8'hFF;
         end
         default: begin
            dly  = DELAY_W'($urandom_range(1, 65535));
            pkts = PKTS_W'($urandom_range(0, 255));
         end
      endcase
      quse = ($urandom_range(0, 4) == 0) ? QUSE_W'($urandom_range(0, 15))
                                         : QUSE_W'($urandom_range(1, 8));
      case ($urandom_range(0, 7))
         0:       tcause = '0;
         1:       tcause = 32'hFFFF_FFFF;
         default: tcause = $urandom;
      endcase
      configure(dly, pkts, quse, tcause);
   endtask

   task automatic test_random_phases();
      for (int phase = 0; phase < 10; phase++) begin
         random_config();
         idle_enable = ($urandom_range(0, 3) != 0);
         for (int n = 0; n < 80; n++) begin
            send_random_item();
            if (n == 40 && $urandom_range(0, 1) != 0)
               drain();
         end
      end
   endtask

   // last stretch runs at full rate on both sides
   task automatic test_full_rate();
      random_config();
      idle_enable = 1'b0;
      for (int n = 0; n < 100; n++)
         send_random_item();
   endtask

   // result side: random stall bursts and the long hold-off
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_len > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (hold_off_len) @(posedge clock);
            hold_off_len = 0;
            rsp_bus.ready <= 1'b1;
         end else if (idle_enable && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // compare each result transfer with the oldest prediction
   task automatic check_result();
      irq_result_type want;
      results_seen++;
      if (pending_results.size() == 0) begin
         $error("result transfer with no request outstanding");
         mismatch_count++;
      end else begin
         want = pending_results[0];
         pending_results.delete(0);
         if (rsp_bus.irq_fire !== want.fire) begin
            $error("irq_fire: expected %0d, got %0d", want.fire, rsp_bus.irq_fire);
            mismatch_count++;
         end
         if (rsp_bus.irq_pending !== want.pend) begin
            $error("irq_pending: expected %0d, got %0d", want.pend, rsp_bus.irq_pending);
            mismatch_count++;
         end
         if (rsp_bus.read_data !== want.rdata) begin
            $error("read_data: expected %h, got %h", want.rdata, rsp_bus.read_data);
            mismatch_count++;
         end
         if (rsp_bus.coalesced_total !== want.total) begin
            $error("coalesced_total: expected %0d, got %0d", want.total,
                   rsp_bus.coalesced_total);
            mismatch_count++;
         end
      end
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            check_result();
      end
   end

   // watchdog on cycles without any transfer
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) ||
             (csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
   end

   // test sequence
   initial begin
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.opcode     <= '0;
      req_bus.queue      <= '0;
      req_bus.cause_bits <= '0;
      req_bus.now        <= '0;
      req_bus.write_bits <= '0;
      csr_bus.valid      <= 1'b0;
      csr_bus.index      <= '0;
      csr_bus.data       <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_default_config();
      test_small_threshold();
      test_timeout_wrap();
      test_packet_threshold();
      test_backpressure();
      test_random_phases();
      test_full_rate();

      drain();
      repeat (END_PAUSE) @(posedge clock);
      $display("covered %0d requests and %0d results over %0d register settings",
               items_sent, results_seen, config_count);
      $display("  with %0d interrupts delivered and %0d queue timeouts, %0d mismatches",
               fires_seen, timeouts_seen, mismatch_count);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// File: interrupt_coalescing_controller.f
hdl/icc_pkg.sv
hdl/icc_if.sv
hdl/icc_ram.sv
hdl/interrupt_coalescing_controller.sv
hdl/icc_checker.sv
sim/tb_interrupt_coalescing_controller.sv
